// ===== src/tfct_pkg.sv =====
package tfct_pkg;

   // default number of receive-time entries
   localparam int STAMP_DEPTH_DEFAULT = 4096;

   // field widths
   localparam int DATA_W   = 8;
   localparam int TIME_W   = 64;
   localparam int RIDX_W   = 12;
   localparam int CLASS_W  = 2;
   localparam int ID_W     = 16;
   localparam int TOTAL_W  = 32;
   localparam int COUNT_W  = 13;
   localparam int OFF_W    = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int LIMIT_W  = 17;

   // item opcodes
   localparam logic OP_FRAME_BYTE = 1'b0;
   localparam logic OP_READ_ENTRY = 1'b1;

   // frame classes
   localparam logic [CLASS_W-1:0] CLASS_OTHER   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_TEST    = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_LATENCY = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BAD_ID  = 2'd3;

   // register index (word address bit)
   localparam logic CSR_IDX_STAMP_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] STAMP_COUNT_RESET = 13'd1;

   // protocol values
   localparam logic [15:0] ETYPE_V4  = 16'h0800;
   localparam logic [15:0] ETYPE_V6  = 16'h86DD;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   // byte offsets inside the frame
   localparam logic [OFF_W-1:0] OFF_ETYPE    = 7'd12;
   localparam logic [OFF_W-1:0] OFF_NH_V6    = 7'd20;
   localparam logic [OFF_W-1:0] OFF_TAG_V6   = 7'd62;
   localparam logic [OFF_W-1:0] OFF_ID_V6    = 7'd70;
   localparam logic [OFF_W-1:0] OFF_PROTO_V4 = 7'd23;
   localparam logic [OFF_W-1:0] OFF_TAG_V4   = 7'd42;
   localparam logic [OFF_W-1:0] OFF_ID_V4    = 7'd50;
   localparam logic [OFF_W-1:0] OFFSET_MAX   = 7'd127;
   localparam logic [OFF_W-1:0] TAG_LEN      = 7'd8;

   // payload tags: "IDENTIFY" for test frames, "Identify" for latency frames
   localparam logic [7:0] TEST_TAG [0:7] = '{8'h49, 8'h44, 8'h45, 8'h4E,
                                             8'h54, 8'h49, 8'h46, 8'h59};
   localparam logic [7:0] LAT_TAG  [0:7] = '{8'h49, 8'h64, 8'h65, 8'h6E,
                                             8'h74, 8'h69, 8'h66, 8'h79};

endpackage

// ===== src/tfct_if.sv =====
interface tfct_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [tfct_pkg::DATA_W-1:0]  data_byte;
   logic                         end_of_frame;
   logic [tfct_pkg::TIME_W-1:0]  time_now;
   logic [tfct_pkg::RIDX_W-1:0]  read_index;

   modport source (output valid, opcode, data_byte, end_of_frame, time_now, read_index,
                   input ready);
   modport sink   (input valid, opcode, data_byte, end_of_frame, time_now, read_index,
                   output ready);
endinterface

interface tfct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tfct_pkg::CLASS_W-1:0]  frame_class;
   logic [tfct_pkg::ID_W-1:0]     frame_id;
   logic [tfct_pkg::TOTAL_W-1:0]  frames_received;
   logic [tfct_pkg::TIME_W-1:0]   stamp_value;

   modport source (output valid, frame_class, frame_id, frames_received, stamp_value,
                   input ready);
   modport sink   (input valid, frame_class, frame_id, frames_received, stamp_value,
                   output ready);
endinterface

// ===== src/test_frame_classifier_timestamp_core.sv =====
// a result is registered in the first result stage and then in the output register
// throughput: one request per cycle unless rsp_ch stalls, set by the single-pass parse
// and one table port; reset: synchronous, active high; after reset the receive-time
// table is swept to zero, one entry per cycle, with req_ch.ready low meanwhile
// configuration writes are taken at any time
module test_frame_classifier_timestamp_core #(
   parameter int STAMP_DEPTH = tfct_pkg::STAMP_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   tfct_req_if.sink                     req_ch,
   tfct_rsp_if.source                   rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tfct_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [tfct_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [tfct_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(STAMP_DEPTH - 1);
   localparam logic [tfct_pkg::LIMIT_W-1:0] DEPTH_LIM = tfct_pkg::LIMIT_W'(STAMP_DEPTH);

   // configuration register
   logic [tfct_pkg::COUNT_W-1:0] stamp_count_ff, stamp_count_in;
   logic                         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      stamp_count_in = stamp_count_ff;
      if (csr_wr && csr_paddr[2] == tfct_pkg::CSR_IDX_STAMP_COUNT) begin
         stamp_count_in = csr_pwdata[tfct_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == tfct_pkg::CSR_IDX_STAMP_COUNT) begin
         csr_prdata = tfct_pkg::CSR_DW'(stamp_count_ff);
      end
   end

   // clearing sweep after reset
   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;

   always_comb begin
      clear_in = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + AW'(1);
         if (clear_cnt_ff == LAST_ENTRY) begin
            clear_in = 1'b0;
         end
      end
   end

   // handshake and pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic move;
   logic accept;
   logic frame_acc;
   logic read_acc;

   assign move = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clear_ff && (!s1_valid_ff || move);
   assign accept = req_ch.valid && req_ch.ready;
   assign frame_acc = accept && (req_ch.opcode == tfct_pkg::OP_FRAME_BYTE);
   assign read_acc = accept && (req_ch.opcode == tfct_pkg::OP_READ_ENTRY);

   // frame parse state
   logic [tfct_pkg::OFF_W-1:0]   offset_ff, offset_in;
   logic [15:0]                  ether_ff, ether_in;
   logic [7:0]                   proto_ff, proto_in;
   logic [1:0]                   flags_ff, flags_in;
   logic [tfct_pkg::ID_W-1:0]    id_ff, id_in;
   logic [tfct_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [tfct_pkg::OFF_W-1:0]   off;
   logic [7:0]                   b;
   logic [1:0]                   flags_base;
   logic [15:0]                  ether_mid;
   logic                         v6, v4, l3;
   logic [tfct_pkg::OFF_W-1:0]   tag_off, id_off, proto_off;
   logic                         in_tag;
   logic [2:0]                   tag_k;
   logic [7:0]                   proto_mid;
   logic [1:0]                   flags_mid;
   logic [tfct_pkg::ID_W-1:0]    id_mid;
   logic                         udp_tagged, lat_full, id_ok;
   logic [tfct_pkg::CLASS_W-1:0] frame_cls;
   logic                         count_ev;
   logic                         stamp_wr;

   // single-pass byte parse
   always_comb begin
      off = offset_ff;
      b = req_ch.data_byte;
      flags_base = (off == '0) ? 2'b11 : flags_ff;

      ether_mid = ether_ff;
      if (off == tfct_pkg::OFF_ETYPE) begin
         ether_mid = {b, ether_ff[7:0]};
      end else if (off == tfct_pkg::OFF_ETYPE + 7'd1) begin
         ether_mid = {ether_ff[15:8], b};
      end

      v6 = (ether_mid == tfct_pkg::ETYPE_V6);
      v4 = (ether_mid == tfct_pkg::ETYPE_V4);
      tag_off = v6 ? tfct_pkg::OFF_TAG_V6 : tfct_pkg::OFF_TAG_V4;
      id_off = v6 ? tfct_pkg::OFF_ID_V6 : tfct_pkg::OFF_ID_V4;
      proto_off = v6 ? tfct_pkg::OFF_NH_V6 : tfct_pkg::OFF_PROTO_V4;
      l3 = (v6 || v4) && (off >= tfct_pkg::OFF_ETYPE + 7'd2);

      proto_mid = (l3 && off == proto_off) ? b : proto_ff;

      in_tag = l3 && (off >= tag_off) && (off < tag_off + tfct_pkg::TAG_LEN);
      tag_k = 3'(off - tag_off);
      flags_mid[0] = flags_base[0] && !(in_tag && b != tfct_pkg::TEST_TAG[tag_k]);
      flags_mid[1] = flags_base[1] && !(in_tag && b != tfct_pkg::LAT_TAG[tag_k]);

      id_mid = id_ff;
      if (l3 && off == id_off) begin
         id_mid = {id_ff[15:8], b};
      end else if (l3 && off == id_off + 7'd1) begin
         id_mid = {b, id_ff[7:0]};
      end

      // end-of-frame classification
      udp_tagged = (v6 || v4) && (proto_mid == tfct_pkg::PROTO_UDP)
                   && (off >= tag_off + 7'd7);
      lat_full = flags_mid[1] && (off >= id_off + 7'd1);
      id_ok = (tfct_pkg::LIMIT_W'(id_mid) < tfct_pkg::LIMIT_W'(stamp_count_ff))
              && (tfct_pkg::LIMIT_W'(id_mid) < DEPTH_LIM);
      frame_cls = tfct_pkg::CLASS_OTHER;
      if (udp_tagged) begin
         if (flags_mid[0]) begin
            frame_cls = tfct_pkg::CLASS_TEST;
         end else if (lat_full) begin
            frame_cls = id_ok ? tfct_pkg::CLASS_LATENCY : tfct_pkg::CLASS_BAD_ID;
         end
      end

      count_ev = frame_acc && req_ch.end_of_frame
                 && (frame_cls == tfct_pkg::CLASS_TEST || frame_cls == tfct_pkg::CLASS_LATENCY);
      stamp_wr = frame_acc && req_ch.end_of_frame && (frame_cls == tfct_pkg::CLASS_LATENCY);

      total_in = total_ff;
      if (count_ev && total_ff != '1) begin
         total_in = total_ff + tfct_pkg::TOTAL_W'(1);
      end

      // state update on a frame byte transfer
      offset_in = offset_ff;
      ether_in = ether_ff;
      proto_in = proto_ff;
      flags_in = flags_ff;
      id_in = id_ff;
      if (frame_acc) begin
         ether_in = ether_mid;
         proto_in = proto_mid;
         flags_in = flags_mid;
         id_in = id_mid;
         if (req_ch.end_of_frame) begin
            offset_in = '0;
         end else if (off < tfct_pkg::OFFSET_MAX) begin
            offset_in = off + 7'd1;
         end
      end
   end

   // first result stage
   logic [tfct_pkg::CLASS_W-1:0] s1_class_ff, s1_class_in;
   logic [tfct_pkg::ID_W-1:0]    s1_id_ff, s1_id_in;
   logic [tfct_pkg::TOTAL_W-1:0] s1_total_ff, s1_total_in;
   logic                         s1_read_ok_ff, s1_read_ok_in;
   logic                         load_s1;

   assign load_s1 = accept && (read_acc || req_ch.end_of_frame);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (move) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = load_s1;
      end
      s1_class_in = read_acc ? tfct_pkg::CLASS_OTHER : frame_cls;
      s1_id_in = (frame_cls == tfct_pkg::CLASS_LATENCY || frame_cls == tfct_pkg::CLASS_BAD_ID)
                 && !read_acc ? id_mid : '0;
      s1_total_in = total_in;
      s1_read_ok_in = read_acc
                      && (tfct_pkg::LIMIT_W'(req_ch.read_index) < DEPTH_LIM);
   end

   // receive-time table, one write port and one registered read port
   logic [tfct_pkg::TIME_W-1:0] stamp_mem [STAMP_DEPTH];
   logic [tfct_pkg::TIME_W-1:0] rdata_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [tfct_pkg::TIME_W-1:0] mem_wdata;
   logic [AW-1:0]               mem_raddr;
   logic [tfct_pkg::LIMIT_W-1:0] rd_wide;

   assign rd_wide = tfct_pkg::LIMIT_W'(req_ch.read_index);
   assign mem_raddr = rd_wide[AW-1:0];

   always_comb begin
      mem_we = clear_ff || stamp_wr;
      mem_waddr = clear_ff ? clear_cnt_ff : id_mid[AW-1:0];
      mem_wdata = clear_ff ? '0 : req_ch.time_now;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[mem_waddr] <= mem_wdata;
      end
      if (read_acc) begin
         rdata_ff <= stamp_mem[mem_raddr];
      end
   end

   // output register
   logic [tfct_pkg::CLASS_W-1:0] out_class_ff, out_class_in;
   logic [tfct_pkg::ID_W-1:0]    out_id_ff, out_id_in;
   logic [tfct_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [tfct_pkg::TIME_W-1:0]  out_stamp_ff, out_stamp_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in = 1'b1;
      end
      out_class_in = s1_class_ff;
      out_id_in = s1_id_ff;
      out_total_in = s1_total_ff;
      out_stamp_in = s1_read_ok_ff ? rdata_ff : '0;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.frame_class = out_class_ff;
   assign rsp_ch.frame_id = out_id_ff;
   assign rsp_ch.frames_received = out_total_ff;
   assign rsp_ch.stamp_value = out_stamp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_count_ff <= tfct_pkg::STAMP_COUNT_RESET;
         clear_ff <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         offset_ff <= '0;
         ether_ff <= '0;
         proto_ff <= '0;
         flags_ff <= '0;
         id_ff <= '0;
         total_ff <= '0;
      end else begin
         stamp_count_ff <= stamp_count_in;
         clear_ff <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         offset_ff <= offset_in;
         ether_ff <= ether_in;
         proto_ff <= proto_in;
         flags_ff <= flags_in;
         id_ff <= id_in;
         total_ff <= total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_class_ff <= s1_class_in;
         s1_id_ff <= s1_id_in;
         s1_total_ff <= s1_total_in;
         s1_read_ok_ff <= s1_read_ok_in;
      end
      if (move) begin
         out_class_ff <= out_class_in;
         out_id_ff <= out_id_in;
         out_total_ff <= out_total_in;
         out_stamp_ff <= out_stamp_in;
      end
   end

endmodule

// ===== src/tfct_checker.sv =====
module tfct_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tfct_pkg::CLASS_W-1:0] rsp_frame_class,
   input logic [tfct_pkg::ID_W-1:0]    rsp_frame_id,
   input logic [tfct_pkg::TIME_W-1:0]  rsp_stamp_value,
   input logic                         csr_pready
);

   // table sweep holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken during table sweep");

   // test, latency and bad-id results never carry a table value
   a_frame_no_stamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_class != tfct_pkg::CLASS_OTHER |-> rsp_stamp_value == '0)
      else $error("frame result with nonzero stamp value");

   // only latency classes carry an id
   a_id_only_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_class == tfct_pkg::CLASS_OTHER
                    || rsp_frame_class == tfct_pkg::CLASS_TEST) |-> rsp_frame_id == '0)
      else $error("id on a non-latency result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_class)
                                  && $stable(rsp_frame_id) && $stable(rsp_stamp_value))
      else $error("stalled result changed");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind test_frame_classifier_timestamp_core tfct_checker u_tfct_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_frame_class (rsp_ch.frame_class),
   .rsp_frame_id    (rsp_ch.frame_id),
   .rsp_stamp_value (rsp_ch.stamp_value),
   .csr_pready      (csr_pready)
);

// ===== tb/test_frame_classifier_timestamp_core_checker.sv =====
module test_frame_classifier_timestamp_core_checker
   import tfct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tfct_req_if                req_ch,
   tfct_rsp_if                rsp_ch,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   input  logic [CSR_DW-1:0]  csr_prdata,
   input  logic               csr_pready,
   input  logic               run_done,
   output int                 fail_count,
   output int                 expected_left,
   output int                 frames_checked,
   output int                 reads_checked
);

   localparam int TABLE_DEPTH = STAMP_DEPTH_DEFAULT;

   typedef struct packed {
      logic                from_read;
      logic [CLASS_W-1:0]  frame_class;
      logic [ID_W-1:0]     frame_id;
      logic [TOTAL_W-1:0]  frames_received;
      logic [TIME_W-1:0]   stamp_value;
   } frame_result_type;

   // shadow of the block: parser state, receive-time table, counter, register
   logic [OFF_W-1:0]    parse_offset;
   logic [15:0]         ether_kind;
   logic [7:0]          proto_seen;
   logic [1:0]          tag_match;
   logic [ID_W-1:0]     lat_id;
   logic [TIME_W-1:0]   arrival_time [0:TABLE_DEPTH-1];
   logic [TOTAL_W-1:0]  frame_total;
   logic [COUNT_W-1:0]  stamp_limit;

   frame_result_type    pending_results [$];
   int                  mismatches;
   int                  n_frames;
   int                  n_reads;
   bit                  leftovers_done;

   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] wanted);
      mismatches++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
   endtask

   // one frame byte through the parser; returns 1 when the byte ends a frame
   function automatic bit classify_byte(input logic [DATA_W-1:0] b, input logic eof,
                                        input logic [TIME_W-1:0] now,
                                        output frame_result_type res);
      int off;
      int tag_at;
      int id_at;
      int proto_at;
      int len;
      bit v6;
      bit v4;
      res = '0;
      off = int'(parse_offset);
      if (off == 0) tag_match = 2'b11;
      if (off == int'(OFF_ETYPE)) ether_kind[15:8] = b;
      else if (off == int'(OFF_ETYPE) + 1) ether_kind[7:0] = b;

      v6 = (ether_kind == ETYPE_V6);
      v4 = (ether_kind == ETYPE_V4);
      tag_at = v6 ? int'(OFF_TAG_V6) : int'(OFF_TAG_V4);
      id_at = v6 ? int'(OFF_ID_V6) : int'(OFF_ID_V4);
      proto_at = v6 ? int'(OFF_NH_V6) : int'(OFF_PROTO_V4);

      // header fields only count once the ethertype is known
      if ((v6 || v4) && off >= int'(OFF_ETYPE) + 2) begin
         if (off == proto_at) proto_seen = b;
         if (off >= tag_at && off < tag_at + int'(TAG_LEN)) begin
            if (b != TEST_TAG[off - tag_at]) tag_match[0] = 1'b0;
            if (b != LAT_TAG[off - tag_at]) tag_match[1] = 1'b0;
         end
         if (off == id_at) lat_id[7:0] = b;
         else if (off == id_at + 1) lat_id[15:8] = b;
      end

      if (!eof) begin
         parse_offset = (off < int'(OFFSET_MAX)) ? OFF_W'(off + 1) : OFFSET_MAX;
         return 1'b0;
      end

      // end of frame: decide the class
      len = off + 1;
      parse_offset = '0;
      res.frame_class = CLASS_OTHER;
      if ((v6 || v4) && proto_seen == PROTO_UDP && len >= tag_at + int'(TAG_LEN)) begin
         if (tag_match[0]) begin
            res.frame_class = CLASS_TEST;
            if (frame_total != '1) frame_total++;
         end else if (tag_match[1] && len >= id_at + 2) begin
            res.frame_id = lat_id;
            if (lat_id < stamp_limit && int'(lat_id) < TABLE_DEPTH) begin
               arrival_time[lat_id] = now;
               res.frame_class = CLASS_LATENCY;
               if (frame_total != '1) frame_total++;
            end else begin
               res.frame_class = CLASS_BAD_ID;
            end
         end
      end
      res.frames_received = frame_total;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      frame_result_type want;
      frame_result_type made;
      if (reset) begin
         parse_offset = '0;
         ether_kind = '0;
         proto_seen = '0;
         tag_match = '0;
         lat_id = '0;
         frame_total = '0;
         stamp_limit = STAMP_COUNT_RESET;
         foreach (arrival_time[i]) arrival_time[i] = '0;
         pending_results.delete();
      end else begin
         // register port
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_AW-1:2] == CSR_IDX_STAMP_COUNT) begin
            if (csr_pwrite) stamp_limit = csr_pwdata[COUNT_W-1:0];
            else if (csr_prdata !== CSR_DW'(stamp_limit))
               report_mismatch("stamp_count readback", 64'(csr_prdata), 64'(stamp_limit));
         end

         // result transfer against the oldest expectation
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected, frame_class",
                               64'(rsp_ch.frame_class), 64'(0));
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.frame_class !== want.frame_class)
                  report_mismatch("frame_class", 64'(rsp_ch.frame_class),
                                  64'(want.frame_class));
               if (rsp_ch.frame_id !== want.frame_id)
                  report_mismatch("frame_id", 64'(rsp_ch.frame_id), 64'(want.frame_id));
               if (rsp_ch.frames_received !== want.frames_received)
                  report_mismatch("frames_received", 64'(rsp_ch.frames_received),
                                  64'(want.frames_received));
               if (rsp_ch.stamp_value !== want.stamp_value)
                  report_mismatch("stamp_value", rsp_ch.stamp_value, want.stamp_value);
               if (want.from_read) n_reads++;
               else n_frames++;
            end
         end

         // request transfer
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (req_ch.opcode == OP_READ_ENTRY) begin
               made = '0;
               made.from_read = 1'b1;
               made.frame_class = CLASS_OTHER;
               made.frames_received = frame_total;
               made.stamp_value = (int'(req_ch.read_index) < TABLE_DEPTH) ?
                                  arrival_time[req_ch.read_index] : '0;
               pending_results.push_back(made);
            end else if (classify_byte(req_ch.data_byte, req_ch.end_of_frame,
                                       req_ch.time_now, made)) begin
               pending_results.push_back(made);
            end
         end

         // anything still waiting at the end is lost
         if (run_done && !leftovers_done) begin
            leftovers_done = 1'b1;
            while (pending_results.size() != 0) begin
               want = pending_results.pop_front();
               report_mismatch("result never delivered, frame_class", 64'(0),
                               64'(want.frame_class));
            end
         end
      end
      expected_left <= pending_results.size();
      fail_count <= mismatches;
      frames_checked <= n_frames;
      reads_checked <= n_reads;
   end

endmodule

// ===== tb/test_frame_classifier_timestamp_core_tb.sv =====
module test_frame_classifier_timestamp_core_tb;
   import tfct_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int DRAIN_CYCLES   = 4;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int PHASE_ITEMS    = 50;
   localparam int PHASE_FRAMES   = 1;
   localparam int USED_ID_KEEP   = 64;

   localparam logic [CSR_AW-1:0] STAMP_COUNT_ADDR = CSR_AW'({CSR_IDX_STAMP_COUNT, 2'b00});
   localparam logic [CSR_AW-1:0] SPARE_ADDR       = CSR_AW'({~CSR_IDX_STAMP_COUNT, 2'b00});

   typedef enum int {L3_V4, L3_V6, L3_OTHER} l3_kind_type;
   typedef enum int {TAG_TEST, TAG_LATENCY, TAG_MIXED, TAG_JUNK} payload_tag_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   logic                run_done;
   logic                gaps_on;

   int                  fail_count;
   int                  expected_left;
   int                  frames_checked;
   int                  reads_checked;
   int                  items_sent;
   int                  frames_sent;
   int                  rsp_stall;
   int                  stamp_setting;
   logic [ID_W-1:0]     used_ids [$];
   int                  phase_limits [3] = '{37, 4095, 4096};

   tfct_req_if req_ch ();
   tfct_rsp_if rsp_ch ();

   test_frame_classifier_timestamp_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   test_frame_classifier_timestamp_core_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .run_done       (run_done),
      .fail_count     (fail_count),
      .expected_left  (expected_left),
      .frames_checked (frames_checked),
      .reads_checked  (reads_checked)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // result side backpressure in bursts of random length
   always @(posedge clock) begin
      if (!gaps_on) begin
         rsp_ch.ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 9);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // one request transfer, with an occasional idle burst ahead of it
   task automatic send_item(input logic op, input logic [DATA_W-1:0] b, input logic eof,
                            input logic [TIME_W-1:0] now, input logic [RIDX_W-1:0] idx);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.data_byte <= b;
      req_ch.end_of_frame <= eof;
      req_ch.time_now <= now;
      req_ch.read_index <= idx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   // table read; the frame fields carry noise that the block must ignore
   task automatic send_read(input logic [RIDX_W-1:0] idx);
      send_item(OP_READ_ENTRY, DATA_W'($urandom), 1'($urandom), {$urandom, $urandom}, idx);
   endtask

   // mostly ids recently sent in latency frames, otherwise anywhere in the table
   function automatic logic [RIDX_W-1:0] pick_read_index();
      if (used_ids.size() != 0 && $urandom_range(0, 2) != 0)
         return RIDX_W'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
      return RIDX_W'($urandom);
   endfunction

   // build a frame on the fly and stream it, table reads mixed in at read_pct percent
   task automatic send_frame(input l3_kind_type l3, input logic [7:0] proto,
                             input payload_tag_type tag, input logic [ID_W-1:0] id,
                             input int len, input logic [TIME_W-1:0] eof_time,
                             input int read_pct);
      int tag_at;
      int id_at;
      int proto_at;
      int mix_at;
      logic [15:0] etype;
      logic [DATA_W-1:0] b;
      tag_at = (l3 == L3_V6) ? int'(OFF_TAG_V6) : int'(OFF_TAG_V4);
      id_at = (l3 == L3_V6) ? int'(OFF_ID_V6) : int'(OFF_ID_V4);
      proto_at = (l3 == L3_V6) ? int'(OFF_NH_V6) : int'(OFF_PROTO_V4);
      mix_at = $urandom_range(1, 7);
      case (l3)
         L3_V4: etype = ETYPE_V4;
         L3_V6: etype = ETYPE_V6;
         default: begin
            etype = 16'($urandom);
            if (etype == ETYPE_V4 || etype == ETYPE_V6) etype = ~etype;
         end
      endcase
      if (tag == TAG_LATENCY && id < stamp_setting) begin
         used_ids.push_back(id);
         if (used_ids.size() > USED_ID_KEEP) void'(used_ids.pop_front());
      end
      for (int i = 0; i < len; i++) begin
         if (i == int'(OFF_ETYPE)) b = etype[15:8];
         else if (i == int'(OFF_ETYPE) + 1) b = etype[7:0];
         else if (i == proto_at) b = proto;
         else if (i >= tag_at && i < tag_at + int'(TAG_LEN)) begin
            case (tag)
               TAG_TEST: b = TEST_TAG[i - tag_at];
               TAG_LATENCY: b = LAT_TAG[i - tag_at];
               TAG_MIXED: b = (i - tag_at < mix_at) ? TEST_TAG[i - tag_at] : LAT_TAG[i - tag_at];
               default: b = DATA_W'($urandom);
            endcase
         end else if (i == id_at) b = id[7:0];
         else if (i == id_at + 1) b = id[15:8];
         else b = DATA_W'($urandom);
         if ($urandom_range(0, 99) < read_pct) send_read(pick_read_index());
         send_item(OP_FRAME_BYTE, b, 1'(i == len - 1),
                   (i == len - 1) ? eof_time : {$urandom, $urandom}, RIDX_W'($urandom));
      end
      frames_sent++;
   endtask

   // mostly well-formed test and latency frames, the rest broken or foreign
   task automatic random_frame();
      int pick;
      int full_len;
      int len;
      l3_kind_type l3;
      payload_tag_type tag;
      logic [7:0] proto;
      logic [ID_W-1:0] id;
      pick = $urandom_range(0, 99);
      l3 = (pick < 45) ? L3_V4 : (pick < 92) ? L3_V6 : L3_OTHER;
      proto = ($urandom_range(0, 11) == 0) ? 8'($urandom) : PROTO_UDP;
      pick = $urandom_range(0, 99);
      tag = (pick < 30) ? TAG_TEST : (pick < 85) ? TAG_LATENCY :
            (pick < 93) ? TAG_MIXED : TAG_JUNK;
      pick = $urandom_range(0, 99);
      if (pick < 80) id = ID_W'($urandom_range(0, stamp_setting - 1));
      else if (pick < 92) id = ID_W'(stamp_setting + $urandom_range(0, 255));
      else id = ID_W'($urandom);
      full_len = ((l3 == L3_V6) ? int'(OFF_ID_V6) : int'(OFF_ID_V4)) + 2;
      pick = $urandom_range(0, 99);
      if (pick < 8) len = $urandom_range(1, full_len - 1);
      else if (pick < 12) len = $urandom_range(int'(OFFSET_MAX) + 1, 190);
      else len = full_len + $urandom_range(0, 6);
      send_frame(l3, proto, tag, id, len, {$urandom, $urandom}, 2);
   endtask

   // wait until every expected result is in and the pipeline has drained
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_AW-1:0] addr);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_stamp_count(input int value);
      csr_write(STAMP_COUNT_ADDR, CSR_DW'(value));
      csr_read(STAMP_COUNT_ADDR);
      stamp_setting = value;
   endtask

   initial begin
      int phase_start;
      int phase_frames;
      reset = 1'b1;
      gaps_on = 1'b0;
      run_done = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_FRAME_BYTE;
      req_ch.data_byte = '0;
      req_ch.end_of_frame = 1'b0;
      req_ch.time_now = '0;
      req_ch.read_index = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stamp_setting = int'(STAMP_COUNT_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      gaps_on <= 1'b1;

      // reset value of the register: only id 0 is valid
      csr_read(STAMP_COUNT_ADDR);
      send_read('0);
      send_read('1);
      send_frame(L3_V6, PROTO_UDP, TAG_TEST, '0, int'(OFF_TAG_V6) + int'(TAG_LEN), '1, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_TEST, '0, int'(OFF_TAG_V4) + int'(TAG_LEN), '1, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_LATENCY, '0, OFF_ID_V4 + 2, '1, 0);
      send_frame(L3_V6, PROTO_UDP, TAG_LATENCY, ID_W'(1), OFF_ID_V6 + 2, '1, 0);
      send_read('0);

      // full table, plus a write to an address with no register behind it
      wait_idle();
      csr_write(SPARE_ADDR, CSR_DW'($urandom));
      set_stamp_count(STAMP_DEPTH_DEFAULT);
      send_frame(L3_V6, PROTO_UDP, TAG_LATENCY, ID_W'(STAMP_DEPTH_DEFAULT - 1),
                 OFF_ID_V6 + 2, {$urandom, $urandom}, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_LATENCY, '0, OFF_ID_V4 + 2, '0, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_LATENCY, ID_W'(STAMP_DEPTH_DEFAULT),
                 OFF_ID_V4 + 2, '1, 0);
      send_frame(L3_V6, PROTO_UDP, TAG_LATENCY, '1, OFF_ID_V6 + 2, '1, 0);

      // short frames: tag cut off, id cut off, runt frames
      send_frame(L3_V4, PROTO_UDP, TAG_TEST, '0, OFF_TAG_V4 + TAG_LEN - 1, '1, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_LATENCY, ID_W'(5), OFF_ID_V4 + 1, '1, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_TEST, '0, 1, '1, 0);
      send_frame(L3_V6, PROTO_UDP, TAG_TEST, '0, OFF_ETYPE + 2, '1, 0);

      // foreign ethertype, non-udp protocol, mixed tag, long frame with reads inside
      send_frame(L3_OTHER, PROTO_UDP, TAG_TEST, '0, int'(OFF_TAG_V4) + int'(TAG_LEN), '1, 0);
      send_frame(L3_V6, 8'd6, TAG_TEST, '0, int'(OFF_TAG_V6) + int'(TAG_LEN), '1, 0);
      send_frame(L3_V6, PROTO_UDP, TAG_MIXED, ID_W'(9), OFF_ID_V6 + 2, '1, 0);
      send_frame(L3_V4, PROTO_UDP, TAG_LATENCY, ID_W'(2047), 140, {$urandom, $urandom}, 5);
      send_read('0);
      send_read(RIDX_W'(STAMP_DEPTH_DEFAULT - 1));

      // random phases over several register settings, the last one without idling
      foreach (phase_limits[p]) begin
         wait_idle();
         if (p == $size(phase_limits) - 1) gaps_on <= 1'b0;
         set_stamp_count(phase_limits[p]);
         phase_start = items_sent;
         phase_frames = 0;
         while (items_sent - phase_start < PHASE_ITEMS || phase_frames < PHASE_FRAMES) begin
            if (p != $size(phase_limits) - 1) gaps_on <= 1'($urandom_range(0, 3) != 0);
            random_frame();
            phase_frames++;
            if ($urandom_range(0, 4) == 0) send_read(pick_read_index());
         end
      end

      wait_idle();
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      $display("covered %0d request transfers in %0d frames, stamp_count from 1 to %0d",
               items_sent, frames_sent, STAMP_DEPTH_DEFAULT);
      $display("checked %0d frame results and %0d table reads",
               frames_checked, reads_checked);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

endmodule
